// ===== design/rbad_pkg.sv =====
// Package with the shared types and constants of the RGB565 block average downscaler.
`default_nettype none

package rbad_pkg;

    localparam int PIX_W     = 16;
    localparam int R_LSB     = 11;
    localparam int R_W       = 5;
    localparam int G_LSB     = 5;
    localparam int G_W       = 6;
    localparam int B_W       = 5;
    localparam int AVG_SHIFT = 6;
    localparam int REG_W     = 6;
    localparam int APB_W     = 32;
    localparam int ADDR_W    = 3;

    localparam logic [R_W-1:0]   R_MAX      = 5'h1F;
    localparam logic [G_W-1:0]   G_MAX      = 6'h3F;
    localparam logic [B_W-1:0]   B_MAX      = 5'h1F;
    localparam logic [REG_W-1:0] SIZE_RESET = 6'd28;

    // Widths that hold a block index or a block count at the largest supported size.
    localparam int CMD_IDX_W = 8;
    localparam int CMD_CNT_W = 9;

    typedef enum logic [0:0] {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [PIX_W-1:0]     pixel;
        logic [CMD_IDX_W-1:0] blk;
        logic [CMD_CNT_W-1:0] w;
        logic                 band_end;
        logic                 frame_end;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_push;

    typedef struct packed {
        logic full;
        logic valid;
        t_cmd head;
    } t_q_stat;

endpackage

`default_nettype wire

// ===== design/rbad_pix_if.sv =====
// Interface for the input pixel channel.
`default_nettype none

interface rbad_pix_if;
    logic                      valid;
    logic                      ready;
    logic [rbad_pkg::PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

`default_nettype wire

// ===== design/rbad_avg_if.sv =====
// Interface for the averaged output pixel channel.
`default_nettype none

interface rbad_avg_if;
    logic                      valid;
    logic                      ready;
    logic [rbad_pkg::PIX_W-1:0] avg_pixel;
    logic                      last_in_row;
    logic                      last_in_frame;

    modport source (output valid, output avg_pixel, output last_in_row,
                    output last_in_frame, input ready);
    modport sink   (input valid, input avg_pixel, input last_in_row,
                    input last_in_frame, output ready);
endinterface

`default_nettype wire

// ===== design/rbad_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rbad_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

`default_nettype wire

// ===== design/rbad_front.sv =====
// Front end: accepts pixels, tracks column, row and band position, and queues commands.
`default_nettype none

module rbad_front #(
    parameter int MAX_BLOCKS = 32,
    parameter int BLOCK_SIZE = 8
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    rbad_pix_if.sink                         i_pix,
    input  wire logic [rbad_pkg::REG_W-1:0]  i_width_blocks,
    input  wire logic [rbad_pkg::REG_W-1:0]  i_height_blocks,
    input  wire rbad_pkg::t_q_stat           i_q_stat,
    output rbad_pkg::t_push                  o_push
);
    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int W_W   = $clog2(MAX_BLOCKS + 1);
    localparam int PC_W  = $clog2(BLOCK_SIZE);
    localparam int CW    = rbad_pkg::CMD_CNT_W;

    logic [IDX_W-1:0] r_blk, n_blk;
    logic [PC_W-1:0]  r_pix, n_pix;
    logic [PC_W-1:0]  r_row, n_row;
    logic [W_W-1:0]   r_band, n_band;

    logic [CW-1:0] wr, hr, w_cl, h_cl, blk_ext, band_inc;
    logic          last_pix, row_end, last_row, band_end, frame_end, accept;

    // Size registers: zero acts as one, anything above the block limit acts as the limit.
    always_comb begin
        wr = CW'(i_width_blocks);
        hr = CW'(i_height_blocks);
        if (wr == '0) begin
            w_cl = CW'(1);
        end else if (wr > CW'(MAX_BLOCKS)) begin
            w_cl = CW'(MAX_BLOCKS);
        end else begin
            w_cl = wr;
        end
        if (hr == '0) begin
            h_cl = CW'(1);
        end else if (hr > CW'(MAX_BLOCKS)) begin
            h_cl = CW'(MAX_BLOCKS);
        end else begin
            h_cl = hr;
        end
    end

    assign accept    = i_pix.valid && i_pix.ready;
    assign blk_ext   = CW'(r_blk);
    assign last_pix  = (r_pix == PC_W'(BLOCK_SIZE - 1));
    // The row ends once the column position reaches or passes the row length.
    assign row_end   = (blk_ext >= w_cl) || (last_pix && ((blk_ext + CW'(1)) >= w_cl));
    assign last_row  = (r_row == PC_W'(BLOCK_SIZE - 1));
    assign band_end  = row_end && last_row;
    assign band_inc  = CW'(r_band) + CW'(1);
    assign frame_end = band_end && (band_inc >= h_cl);

    always_comb begin
        n_blk  = r_blk;
        n_pix  = r_pix;
        n_row  = r_row;
        n_band = r_band;
        if (accept) begin
            if (row_end) begin
                n_blk = '0;
                n_pix = '0;
                n_row = last_row ? '0 : r_row + PC_W'(1);
                if (band_end) begin
                    n_band = frame_end ? '0 : W_W'(band_inc);
                end
            end else if (last_pix) begin
                n_pix = '0;
                n_blk = r_blk + IDX_W'(1);
            end else begin
                n_pix = r_pix + PC_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blk  <= '0;
            r_pix  <= '0;
            r_row  <= '0;
            r_band <= '0;
        end else begin
            r_blk  <= n_blk;
            r_pix  <= n_pix;
            r_row  <= n_row;
            r_band <= n_band;
        end
    end

    assign i_pix.ready = !i_q_stat.full;

    always_comb begin
        o_push.valid         = accept;
        o_push.cmd.pixel     = i_pix.pixel;
        o_push.cmd.blk       = rbad_pkg::CMD_IDX_W'(r_blk);
        o_push.cmd.w         = w_cl;
        o_push.cmd.band_end  = band_end;
        o_push.cmd.frame_end = frame_end;
    end
endmodule

`default_nettype wire

// ===== design/rbad_fifo.sv =====
// Two-entry command queue between the front end and the accumulate engine.
`default_nettype none

module rbad_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire rbad_pkg::t_push   i_push,
    input  wire logic              i_pop,
    output rbad_pkg::t_q_stat      o_stat
);
    rbad_pkg::t_cmd r_mem [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_count, n_count;
    logic           do_push, do_pop;

    assign do_push = i_push.valid && (r_count != 2'd2);
    assign do_pop  = i_pop && (r_count != 2'd0);

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 2'd1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_push.cmd;
        end
    end

    always_comb begin
        o_stat.full  = (r_count == 2'd2);
        o_stat.valid = (r_count != 2'd0);
        o_stat.head  = r_mem[r_rp];
    end
endmodule

`default_nettype wire

// ===== design/rbad_back.sv =====
// Back end: read-modify-write of the block sums, then readout and clearing at band end.
`default_nettype none

module rbad_back #(
    parameter int MAX_BLOCKS = 32,
    parameter int BLOCK_SIZE = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire rbad_pkg::t_q_stat i_q_stat,
    output logic                   o_pop,
    rbad_avg_if.source             o_avg
);
    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int GROW  = 2 * $clog2(BLOCK_SIZE);
    localparam int SR_W  = rbad_pkg::R_W + GROW;
    localparam int SG_W  = rbad_pkg::G_W + GROW;
    localparam int SB_W  = rbad_pkg::B_W + GROW;
    localparam int SUM_W = SR_W + SG_W + SB_W;
    localparam int CW    = rbad_pkg::CMD_CNT_W;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_ACC  = 4'b0010,
        ST_RD   = 4'b0100,
        ST_SHOW = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    rbad_pkg::t_cmd   r_cmd;
    logic [IDX_W-1:0] r_k;
    logic [MAX_BLOCKS-1:0] r_valid;

    logic                      r_out_valid;
    logic [rbad_pkg::PIX_W-1:0] r_out_pixel;
    logic                      r_out_row;
    logic                      r_out_frame;

    logic             ram_we, ram_re;
    logic [IDX_W-1:0] ram_raddr, acc_idx;
    logic [SUM_W-1:0] ram_rdata, ram_wdata, cur_sum;
    logic [SR_W-1:0]  sr, sr_sh;
    logic [SG_W-1:0]  sg, sg_sh;
    logic [SB_W-1:0]  sb, sb_sh;
    logic [rbad_pkg::R_W-1:0] ch_r;
    logic [rbad_pkg::G_W-1:0] ch_g;
    logic [rbad_pkg::B_W-1:0] ch_b;
    logic             sel_valid, out_free, load_out, last_k;

    assign acc_idx = r_cmd.blk[IDX_W-1:0];

    // An entry whose valid bit is clear reads as a cleared sum.
    always_comb begin
        sel_valid = (r_state == ST_ACC) ? r_valid[acc_idx] : r_valid[r_k];
        cur_sum   = sel_valid ? ram_rdata : '0;
        sr        = cur_sum[SUM_W-1 -: SR_W];
        sg        = cur_sum[SB_W +: SG_W];
        sb        = cur_sum[SB_W-1:0];
    end

    always_comb begin
        ram_wdata = {sr + SR_W'(r_cmd.pixel[rbad_pkg::R_LSB +: rbad_pkg::R_W]),
                     sg + SG_W'(r_cmd.pixel[rbad_pkg::G_LSB +: rbad_pkg::G_W]),
                     sb + SB_W'(r_cmd.pixel[rbad_pkg::B_W-1:0])};
    end

    // Average and saturate each channel to its field.
    always_comb begin
        sr_sh = sr >> rbad_pkg::AVG_SHIFT;
        sg_sh = sg >> rbad_pkg::AVG_SHIFT;
        sb_sh = sb >> rbad_pkg::AVG_SHIFT;
        ch_r  = (sr_sh > SR_W'(rbad_pkg::R_MAX)) ? rbad_pkg::R_MAX : sr_sh[rbad_pkg::R_W-1:0];
        ch_g  = (sg_sh > SG_W'(rbad_pkg::G_MAX)) ? rbad_pkg::G_MAX : sg_sh[rbad_pkg::G_W-1:0];
        ch_b  = (sb_sh > SB_W'(rbad_pkg::B_MAX)) ? rbad_pkg::B_MAX : sb_sh[rbad_pkg::B_W-1:0];
    end

    assign out_free = !r_out_valid || o_avg.ready;
    assign last_k   = (CW'(r_k) + CW'(1)) == r_cmd.w;
    assign load_out = (r_state == ST_SHOW) && out_free;
    assign o_pop    = (r_state == ST_IDLE) && i_q_stat.valid;
    assign ram_we   = (r_state == ST_ACC);
    assign ram_re   = o_pop || (r_state == ST_RD);
    assign ram_raddr = (r_state == ST_IDLE) ? i_q_stat.head.blk[IDX_W-1:0] : r_k;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_stat.valid) begin
                    n_state = ST_ACC;
                end
            end
            ST_ACC: begin
                n_state = r_cmd.band_end ? ST_RD : ST_IDLE;
            end
            ST_RD: begin
                n_state = ST_SHOW;
            end
            ST_SHOW: begin
                if (out_free) begin
                    n_state = last_k ? ST_IDLE : ST_RD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_k         <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_ACC) begin
                r_valid[acc_idx] <= 1'b1;
                r_k              <= '0;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
                if (last_k) begin
                    r_valid <= '0;
                end else begin
                    r_k <= r_k + IDX_W'(1);
                end
            end else if (o_avg.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_q_stat.head;
        end
        if (load_out) begin
            r_out_pixel <= {ch_r, ch_g, ch_b};
            r_out_row   <= last_k;
            r_out_frame <= last_k && r_cmd.frame_end;
        end
    end

    rbad_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_BLOCKS)
    ) u_sums (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (acc_idx),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_avg.valid         = r_out_valid;
    assign o_avg.avg_pixel     = r_out_pixel;
    assign o_avg.last_in_row   = r_out_row;
    assign o_avg.last_in_frame = r_out_frame;
endmodule

`default_nettype wire

// ===== design/rgb565_block_average_downscaler_unit.sv =====
// Top level of the RGB565 block average downscaler: APB registers, front end, queue, back end.
// Pixels queue on acceptance; the block sum RAM is updated by read-modify-write, so the next
// pixel is popped with a RAM read only after the last one is written back in ST_ACC. At a band
// end the averages follow one word at a time (RAM read, then output register) as the sink takes them.
// Reset (synchronous, active low) clears counters, queue, sum valid bits and output, and sets
// both size registers to 28; no clearing pass runs, the block accepts pixels right away.
`default_nettype none

module rgb565_block_average_downscaler_unit #(
    parameter int MAX_BLOCKS = 32,
    parameter int BLOCK_SIZE = 8
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    rbad_pix_if.sink                          i_pix,
    rbad_avg_if.source                        o_avg,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [rbad_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [rbad_pkg::APB_W-1:0]   pwdata,
    output logic      [rbad_pkg::APB_W-1:0]   prdata,
    output logic                              pready
);
    logic [rbad_pkg::REG_W-1:0] r_width, r_height;
    logic                       wr_en;
    rbad_pkg::t_reg_idx         reg_idx;
    rbad_pkg::t_push            push;
    rbad_pkg::t_q_stat          q_stat;
    logic                       pop;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = rbad_pkg::t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= rbad_pkg::SIZE_RESET;
            r_height <= rbad_pkg::SIZE_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                rbad_pkg::REG_WIDTH:  r_width  <= pwdata[rbad_pkg::REG_W-1:0];
                rbad_pkg::REG_HEIGHT: r_height <= pwdata[rbad_pkg::REG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            rbad_pkg::REG_WIDTH:  prdata = rbad_pkg::APB_W'(r_width);
            rbad_pkg::REG_HEIGHT: prdata = rbad_pkg::APB_W'(r_height);
            default:              prdata = '0;
        endcase
    end

    rbad_front #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .BLOCK_SIZE (BLOCK_SIZE)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_pix           (i_pix),
        .i_width_blocks  (r_width),
        .i_height_blocks (r_height),
        .i_q_stat        (q_stat),
        .o_push          (push)
    );

    rbad_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_stat  (q_stat)
    );

    rbad_back #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .BLOCK_SIZE (BLOCK_SIZE)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_avg    (o_avg)
    );
endmodule

`default_nettype wire

// ===== design/rbad_checker.sv =====
// Port-level checker for the downscaler, bound to the top level.
`default_nettype none

module rbad_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_out_valid,
    input wire logic                          i_out_ready,
    input wire logic [rbad_pkg::PIX_W-1:0]    i_out_pixel,
    input wire logic                          i_out_row,
    input wire logic                          i_out_frame,
    input wire logic                          i_pready
);
    // A stalled output word holds still.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_pixel)
            && $stable(i_out_row) && $stable(i_out_frame))
        else $error("output word changed while stalled");

    // The frame always ends on the final block of a row.
    a_frame_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_frame |-> i_out_row)
        else $error("frame end without row end");

    // Nothing is offered in the cycle after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> i_pready)
        else $error("configuration port stalled");
endmodule

bind rgb565_block_average_downscaler_unit rbad_checker u_rbad_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_avg.valid),
    .i_out_ready (o_avg.ready),
    .i_out_pixel (o_avg.avg_pixel),
    .i_out_row   (o_avg.last_in_row),
    .i_out_frame (o_avg.last_in_frame),
    .i_pready    (pready)
);

`default_nettype wire
